// File: src/bounded_array_list_engine_core_macros.svh
// Assertion macros used by the checker file of the list engine.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define BALE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define BALE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

// File: src/bale_pkg.sv
// Types and codes shared by the list engine modules.
package bale_pkg;

    typedef enum logic [3:0] {
        F_INSERT    = 4'd0,
        F_REMOVE    = 4'd1,
        F_READ      = 4'd2,
        F_SEARCH    = 4'd3,
        F_REPLACE   = 4'd4,
        F_SINS_UP   = 4'd5,
        F_SINS_DOWN = 4'd6,
        F_SORT_UP   = 4'd7,
        F_SORT_DOWN = 4'd8,
        F_STATUS    = 4'd9
    } t_func;

    typedef enum logic [2:0] {
        C_HOLD,
        C_ROT,
        C_INS,
        C_DEL,
        C_WR,
        C_SWAP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     up;
        logic     par;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_MOD,
        S_SORT,
        S_POST,
        S_DONE
    } t_state;

endpackage

// File: src/bale_if.sv
// Request and response channel interfaces of the list engine.
interface bale_req_if #(
    parameter int CW = 5,
    parameter int DW = 32
);
    logic                 valid;
    logic                 ready;
    logic [3:0]           func;
    logic [CW-1:0]        index;
    logic signed [DW-1:0] value;

    modport source (output valid, func, index, value, input ready);
    modport sink   (input valid, func, index, value, output ready);
endinterface

interface bale_rsp_if #(
    parameter int CW = 5,
    parameter int DW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic signed [DW-1:0] read_value;
    logic [CW-1:0]        position;
    logic [CW-1:0]        count;
    logic                 is_empty;
    logic                 is_full;
    logic                 sorted_up;
    logic                 sorted_down;

    modport source (output valid, ok, read_value, position, count, is_empty, is_full,
                    sorted_up, sorted_down, input ready);
    modport sink   (input valid, ok, read_value, position, count, is_empty, is_full,
                    sorted_up, sorted_down, output ready);
endinterface

// File: src/bale_cell.sv
// One list cell: holds one entry and trades it with its neighbours.
module bale_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int DW  = 32
) (
    input  logic                 i_clk,
    input  bale_pkg::t_cell_ctl  i_ctl,
    input  logic [CW-1:0]        i_pos,
    input  logic [CW-1:0]        i_count,
    input  logic signed [DW-1:0] i_data,
    input  logic signed [DW-1:0] i_left,
    input  logic signed [DW-1:0] i_right,
    output logic signed [DW-1:0] o_data
);
    localparam logic [CW-1:0] L_IDX = CW'(IDX);
    localparam logic [CW-1:0] L_NXT = CW'(IDX + 1);
    localparam logic          L_ODD = ((IDX % 2) == 1);

    logic signed [DW-1:0] r_data;
    logic signed [DW-1:0] n_data;
    logic                 w_lmem;
    logic                 w_rmem;

    // A cell is the left member of a pair when its parity matches the pass,
    // and the right member otherwise; only pairs inside the list take part.
    assign w_lmem = (L_ODD == i_ctl.par) && (L_NXT < i_count);
    assign w_rmem = (IDX >= 1) && (L_ODD != i_ctl.par) && (L_IDX < i_count);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            bale_pkg::C_ROT: n_data = i_right;
            bale_pkg::C_INS: begin
                if (L_IDX > i_pos) begin
                    n_data = i_left;
                end else if (L_IDX == i_pos) begin
                    n_data = i_data;
                end
            end
            bale_pkg::C_DEL: begin
                if (L_IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            bale_pkg::C_WR: begin
                if (L_IDX == i_pos) begin
                    n_data = i_data;
                end
            end
            bale_pkg::C_SWAP: begin
                if (w_lmem && (i_ctl.up ? (i_right < r_data) : (i_right > r_data))) begin
                    n_data = i_right;
                end else if (w_rmem &&
                             (i_ctl.up ? (r_data < i_left) : (r_data > i_left))) begin
                    n_data = i_left;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

// File: src/bounded_array_list_engine_core.sv
// Top level of the list engine: cell ring and request sequencer.
// Each request rotates the ring of cells once through the head cell before the change
// (search, read, order and sorted-insert position) and once after it (order flags),
// with the S_MOD state applying the change. A sort adds one odd-even exchange pass per
// entry held, and S_SORT leaves the passes once they are done. A new request is taken
// while the previous response still waits in the output register.
module bounded_array_list_engine_core #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bale_req_if.sink   i_req,
    bale_rsp_if.source o_rsp
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] L_CAP  = CW'(CAPACITY);
    localparam logic [CW-1:0] L_LAST = CW'(CAPACITY - 1);

    logic signed [DATA_WIDTH-1:0] w_data [CAPACITY];
    bale_pkg::t_cell_ctl          w_ctl;
    logic [CW-1:0]                w_pos;

    bale_pkg::t_state             r_state, n_state;
    bale_pkg::t_func              r_func;
    logic [CW-1:0]                r_idx;
    logic signed [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_k;
    logic [CW-1:0]                r_pass;
    logic                         r_ok;
    logic signed [DATA_WIDTH-1:0] r_rd;
    logic                         r_found;
    logic [CW-1:0]                r_pos;
    logic [CW-1:0]                r_at;
    logic                         r_atf;
    logic                         r_ubad;
    logic                         r_dbad;
    logic signed [DATA_WIDTH-1:0] r_prev;

    logic                         r_ov;
    logic                         r_o_ok;
    logic signed [DATA_WIDTH-1:0] r_o_rd;
    logic [CW-1:0]                r_o_pos;
    logic [CW-1:0]                r_o_count;
    logic                         r_o_ubad;
    logic                         r_o_dbad;

    logic                         w_acc;
    logic                         w_inr;
    logic signed [DATA_WIDTH-1:0] w_head;
    logic [CW-1:0]                w_tgt;
    logic                         w_up;
    logic                         w_sorted_ok;
    logic                         w_mod_ok;
    logic                         w_load;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            bale_cell #(
                .IDX (gi),
                .CW  (CW),
                .DW  (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (w_pos),
                .i_count (r_count),
                .i_data  (r_val),
                .i_left  (w_data[(gi + CAPACITY - 1) % CAPACITY]),
                .i_right (w_data[(gi + 1) % CAPACITY]),
                .o_data  (w_data[gi])
            );
        end
    endgenerate

    assign w_head = w_data[0];
    assign w_inr  = (r_k < r_count);
    assign w_tgt  = (r_idx < r_count) ? r_idx : (r_count - CW'(1));
    assign w_up   = (r_func == bale_pkg::F_SINS_UP) || (r_func == bale_pkg::F_SORT_UP);
    assign w_sorted_ok = !(w_up ? r_ubad : r_dbad) && (r_count < L_CAP);
    assign w_acc  = i_req.valid && i_req.ready;
    assign w_load = (r_state == bale_pkg::S_DONE) && (!r_ov || o_rsp.ready);
    assign i_req.ready = (r_state == bale_pkg::S_IDLE);

    // Outcome of the change step, decided from the state seen by the first scan.
    always_comb begin
        case (r_func)
            bale_pkg::F_INSERT:    w_mod_ok = (r_count < L_CAP) && (r_idx <= r_count);
            bale_pkg::F_REMOVE:    w_mod_ok = (r_idx < r_count);
            bale_pkg::F_READ:      w_mod_ok = (r_count != '0);
            bale_pkg::F_SEARCH:    w_mod_ok = r_found;
            bale_pkg::F_REPLACE:   w_mod_ok = (r_idx < r_count);
            bale_pkg::F_SINS_UP:   w_mod_ok = w_sorted_ok;
            bale_pkg::F_SINS_DOWN: w_mod_ok = w_sorted_ok;
            bale_pkg::F_SORT_UP:   w_mod_ok = 1'b1;
            bale_pkg::F_SORT_DOWN: w_mod_ok = 1'b1;
            bale_pkg::F_STATUS:    w_mod_ok = 1'b1;
            default:               w_mod_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        w_ctl.op  = bale_pkg::C_HOLD;
        w_ctl.up  = w_up;
        w_ctl.par = r_pass[0];
        w_pos     = r_idx;
        case (r_state)
            bale_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_state = bale_pkg::S_PRE;
                end
            end
            bale_pkg::S_PRE: begin
                w_ctl.op = bale_pkg::C_ROT;
                if (r_k == L_LAST) begin
                    n_state = bale_pkg::S_MOD;
                end
            end
            bale_pkg::S_MOD: begin
                n_state = bale_pkg::S_POST;
                case (r_func)
                    bale_pkg::F_INSERT: begin
                        if (w_mod_ok) begin
                            w_ctl.op = bale_pkg::C_INS;
                        end
                    end
                    bale_pkg::F_REMOVE: begin
                        if (w_mod_ok) begin
                            w_ctl.op = bale_pkg::C_DEL;
                        end
                    end
                    bale_pkg::F_REPLACE: begin
                        if (w_mod_ok) begin
                            w_ctl.op = bale_pkg::C_WR;
                        end
                    end
                    bale_pkg::F_SINS_UP, bale_pkg::F_SINS_DOWN: begin
                        w_pos = r_at;
                        if (w_mod_ok) begin
                            w_ctl.op = bale_pkg::C_INS;
                        end
                    end
                    bale_pkg::F_SORT_UP, bale_pkg::F_SORT_DOWN: begin
                        n_state = bale_pkg::S_SORT;
                    end
                    default: w_ctl.op = bale_pkg::C_HOLD;
                endcase
            end
            bale_pkg::S_SORT: begin
                if (r_pass < r_count) begin
                    w_ctl.op = bale_pkg::C_SWAP;
                end else begin
                    n_state = bale_pkg::S_POST;
                end
            end
            bale_pkg::S_POST: begin
                w_ctl.op = bale_pkg::C_ROT;
                if (r_k == L_LAST) begin
                    n_state = bale_pkg::S_DONE;
                end
            end
            bale_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = bale_pkg::S_IDLE;
                end
            end
            default: n_state = bale_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bale_pkg::S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == bale_pkg::S_MOD && w_mod_ok) begin
                if (r_func == bale_pkg::F_INSERT || r_func == bale_pkg::F_SINS_UP ||
                    r_func == bale_pkg::F_SINS_DOWN) begin
                    r_count <= r_count + CW'(1);
                end else if (r_func == bale_pkg::F_REMOVE) begin
                    r_count <= r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bale_pkg::S_IDLE: begin
                r_func  <= bale_pkg::t_func'(i_req.func);
                r_idx   <= i_req.index;
                r_val   <= i_req.value;
                r_k     <= '0;
                r_pass  <= '0;
                r_rd    <= '0;
                r_found <= 1'b0;
                r_pos   <= r_count;
                r_at    <= r_count;
                r_atf   <= 1'b0;
                r_ubad  <= 1'b0;
                r_dbad  <= 1'b0;
            end
            bale_pkg::S_PRE, bale_pkg::S_POST: begin
                r_k    <= (r_k == L_LAST) ? '0 : (r_k + CW'(1));
                r_prev <= w_head;
                if (w_inr) begin
                    if (r_k != '0) begin
                        if (w_head < r_prev) begin
                            r_ubad <= 1'b1;
                        end
                        if (w_head > r_prev) begin
                            r_dbad <= 1'b1;
                        end
                    end
                    if (r_state == bale_pkg::S_PRE) begin
                        if (r_func == bale_pkg::F_READ && r_k == w_tgt) begin
                            r_rd <= w_head;
                        end
                        if (!r_found && w_head == r_val) begin
                            r_found <= 1'b1;
                            r_pos   <= r_k;
                        end
                        if (!r_atf && (w_up ? (r_val < w_head) : (r_val > w_head))) begin
                            r_atf <= 1'b1;
                            r_at  <= r_k;
                        end
                    end
                end
            end
            bale_pkg::S_MOD: begin
                r_ok   <= w_mod_ok;
                r_ubad <= 1'b0;
                r_dbad <= 1'b0;
                if (r_func != bale_pkg::F_SEARCH) begin
                    r_pos <= '0;
                end
            end
            bale_pkg::S_SORT: begin
                r_pass <= r_pass + CW'(1);
            end
            default: r_k <= r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_ok    <= r_ok;
            r_o_rd    <= r_rd;
            r_o_pos   <= r_pos;
            r_o_count <= r_count;
            r_o_ubad  <= r_ubad;
            r_o_dbad  <= r_dbad;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.ok          = r_o_ok;
    assign o_rsp.read_value  = r_o_rd;
    assign o_rsp.position    = r_o_pos;
    assign o_rsp.count       = r_o_count;
    assign o_rsp.is_empty    = (r_o_count == '0);
    assign o_rsp.is_full     = (r_o_count == L_CAP);
    assign o_rsp.sorted_up   = !r_o_ubad;
    assign o_rsp.sorted_down = !r_o_dbad;
endmodule

// File: src/bale_checker.sv
// Port-level checks on the list engine, bound to the top level.
`include "bounded_array_list_engine_core_macros.svh"

module bale_checker #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  i_ready,
    input logic                  i_ok,
    input logic [DATA_WIDTH-1:0] i_read_value,
    input logic [$clog2(CAPACITY+1)-1:0] i_count,
    input logic                  i_is_empty,
    input logic                  i_is_full
);
    localparam int CW = $clog2(CAPACITY + 1);

    `BALE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_count))
    `BALE_ASSERT_IMP(a_empty, i_clk, i_rst_n, i_valid, i_is_empty == (i_count == '0))
    `BALE_ASSERT_IMP(a_bound, i_clk, i_rst_n, i_valid, i_count <= CW'(CAPACITY))
    `BALE_ASSERT_IMP(a_full, i_clk, i_rst_n, i_valid && i_is_full, !i_is_empty || (CAPACITY == 0))
    `BALE_ASSERT_IMP(a_fail, i_clk, i_rst_n, i_valid && !i_ok, i_read_value == '0)
endmodule

bind bounded_array_list_engine_core bale_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
) u_bale_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_rsp.valid),
    .i_ready      (o_rsp.ready),
    .i_ok         (o_rsp.ok),
    .i_read_value (o_rsp.read_value),
    .i_count      (o_rsp.count),
    .i_is_empty   (o_rsp.is_empty),
    .i_is_full    (o_rsp.is_full)
);

// File: tb/tb_bounded_array_list_engine_core.sv
// Self-checking testbench for the bounded array list engine core.
module tb_bounded_array_list_engine_core;

    localparam int CAP = 16;
    localparam int CW = 5;
    localparam int DW = 32;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [3:0] F_UNUSED_LO = 4'd10;
    localparam logic [3:0] F_UNUSED_HI = 4'd15;

    typedef struct {
        logic                 ok;
        logic signed [DW-1:0] read_value;
        logic [CW-1:0]        position;
        logic [CW-1:0]        count;
        logic                 is_empty;
        logic                 is_full;
        logic                 sorted_up;
        logic                 sorted_down;
        bit                   fixed;
        logic                 fixed_ok;
        logic [CW-1:0]        fixed_count;
    } t_rsp;

    typedef struct {
        logic [3:0]           func;
        logic [CW-1:0]        index;
        logic signed [DW-1:0] value;
        bit                   fixed;
        logic                 ok;
        logic [CW-1:0]        count;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors = 0;
    int   cycles = 0;
    bit   calm = 1'b0;
    int   stall_left = 0;

    bale_req_if #(.CW(CW), .DW(DW)) req_if ();
    bale_rsp_if #(.CW(CW), .DW(DW)) rsp_if ();

    bounded_array_list_engine_core #(.CAPACITY(CAP), .DATA_WIDTH(DW)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the list contents.
    logic signed [DW-1:0] shadow_list[CAP];
    int                   shadow_count = 0;
    t_rsp                 pending_rsps[$];

    t_row steps[22] = '{
        '{bale_pkg::F_STATUS,    5'd0,  32'sd0,          1'b1, 1'b1, 5'd0},
        '{bale_pkg::F_REMOVE,    5'd0,  32'sd0,          1'b1, 1'b0, 5'd0},
        '{bale_pkg::F_READ,      5'd0,  32'sd0,          1'b1, 1'b0, 5'd0},
        '{bale_pkg::F_INSERT,    5'd1,  32'sd5,          1'b1, 1'b0, 5'd0},
        '{bale_pkg::F_INSERT,    5'd0,  32'h7fff_ffff,   1'b1, 1'b1, 5'd1},
        '{bale_pkg::F_INSERT,    5'd1,  32'h8000_0000,   1'b1, 1'b1, 5'd2},
        '{bale_pkg::F_INSERT,    5'd1,  32'sd0,          1'b1, 1'b1, 5'd3},
        '{bale_pkg::F_INSERT,    5'd3,  -32'sd1,         1'b1, 1'b1, 5'd4},
        '{bale_pkg::F_INSERT,    5'd6,  32'sd1,          1'b1, 1'b0, 5'd4},
        '{bale_pkg::F_SEARCH,    5'd0,  32'sd0,          1'b0, 1'b0, 5'd0},
        '{bale_pkg::F_SEARCH,    5'd0,  32'sd12345,      1'b0, 1'b0, 5'd0},
        '{bale_pkg::F_REPLACE,   5'd4,  32'sd9,          1'b1, 1'b0, 5'd4},
        '{bale_pkg::F_REPLACE,   5'd2,  -32'sd5,         1'b0, 1'b0, 5'd0},
        '{bale_pkg::F_READ,      5'd16, 32'sd0,          1'b0, 1'b0, 5'd0},
        '{bale_pkg::F_SORT_UP,   5'd0,  32'sd0,          1'b1, 1'b1, 5'd4},
        '{bale_pkg::F_SINS_UP,   5'd0,  32'sd3,          1'b0, 1'b0, 5'd0},
        '{bale_pkg::F_SINS_DOWN, 5'd0,  32'sd3,          1'b1, 1'b0, 5'd5},
        '{bale_pkg::F_SORT_DOWN, 5'd0,  32'sd0,          1'b1, 1'b1, 5'd5},
        '{bale_pkg::F_SINS_DOWN, 5'd0,  -32'sd7,         1'b0, 1'b0, 5'd0},
        '{bale_pkg::F_REMOVE,    5'd6,  32'sd0,          1'b1, 1'b0, 5'd6},
        '{F_UNUSED_LO,           5'd0,  32'sd0,          1'b1, 1'b0, 5'd6},
        '{F_UNUSED_HI,           5'd0,  32'sd0,          1'b1, 1'b0, 5'd6}
    };

    function automatic bit list_ordered(bit up);
        for (int i = 1; i < shadow_count; i++) begin
            if (up ? shadow_list[i] < shadow_list[i-1] : shadow_list[i] > shadow_list[i-1])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit list_insert(int at, logic signed [DW-1:0] word);
        if (shadow_count >= CAP || at > shadow_count)
            return 1'b0;
        for (int i = shadow_count; i > at; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[at] = word;
        shadow_count++;
        return 1'b1;
    endfunction

    function automatic void list_sort(bit up);
        logic signed [DW-1:0] word;
        int j;
        for (int i = 1; i < shadow_count; i++) begin
            word = shadow_list[i];
            j = i;
            while (j > 0 && (up ? word < shadow_list[j-1] : word > shadow_list[j-1])) begin
                shadow_list[j] = shadow_list[j-1];
                j--;
            end
            shadow_list[j] = word;
        end
    endfunction

    // Applies one request to the shadow list and returns the response it should give.
    function automatic t_rsp apply_request(logic [3:0] func, int idx, logic signed [DW-1:0] val);
        t_rsp r;
        int at;
        bit up;
        r = '{default: '0};
        case (func)
            bale_pkg::F_INSERT: r.ok = list_insert(idx, val);
            bale_pkg::F_REMOVE: begin
                if (idx < shadow_count) begin
                    for (int i = idx; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            bale_pkg::F_READ: begin
                if (shadow_count > 0) begin
                    r.read_value = shadow_list[idx < shadow_count ? idx : shadow_count - 1];
                    r.ok = 1'b1;
                end
            end
            bale_pkg::F_SEARCH: begin
                r.position = CW'(shadow_count);
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_list[i] == val) begin
                        r.position = CW'(i);
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            bale_pkg::F_REPLACE: begin
                if (idx < shadow_count) begin
                    shadow_list[idx] = val;
                    r.ok = 1'b1;
                end
            end
            bale_pkg::F_SINS_UP, bale_pkg::F_SINS_DOWN: begin
                up = (func == bale_pkg::F_SINS_UP);
                if (list_ordered(up) && shadow_count < CAP) begin
                    at = shadow_count;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (up ? val < shadow_list[i] : val > shadow_list[i]) begin
                            at = i;
                            break;
                        end
                    end
                    r.ok = list_insert(at, val);
                end
            end
            bale_pkg::F_SORT_UP: begin
                list_sort(1'b1);
                r.ok = 1'b1;
            end
            bale_pkg::F_SORT_DOWN: begin
                list_sort(1'b0);
                r.ok = 1'b1;
            end
            bale_pkg::F_STATUS: r.ok = 1'b1;
            default: r.ok = 1'b0;
        endcase
        r.count       = CW'(shadow_count);
        r.is_empty    = (shadow_count == 0);
        r.is_full     = (shadow_count == CAP);
        r.sorted_up   = list_ordered(1'b1);
        r.sorted_down = list_ordered(1'b0);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drives one request and records its expected response once it is taken.
    task automatic send_request(logic [3:0] func, logic [CW-1:0] idx, logic signed [DW-1:0] val,
                                bit fixed, logic fix_ok, logic [CW-1:0] fix_count);
        int gap;
        t_rsp r;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= func;
        req_if.index <= idx;
        req_if.value <= val;
        do @(posedge i_clk); while (!req_if.ready);
        r = apply_request(func, idx, val);
        r.fixed = fixed;
        r.fixed_ok = fix_ok;
        r.fixed_count = fix_count;
        pending_rsps.push_back(r);
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return DW'($signed($urandom_range(0, 12)) - 6);
        if (roll < 65)
            return (roll & 1) ? 32'h7fff_ffff : 32'h8000_0000;
        return $urandom();
    endfunction

    // Response side: random back-pressure and the comparison.
    always @(posedge i_clk) begin
        t_rsp want;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("bounded_array_list_engine_core test failed");
            $finish;
        end else begin
            if (cycles % 300 == 0)
                calm <= ($urandom_range(0, 3) == 0);
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    rsp_if.ready <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < 25) begin
                    stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(0, 3);
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                end
                if (rsp_if.valid && rsp_if.ready) begin
                    if (pending_rsps.size() == 0) begin
                        report("unexpected response", 1, 0);
                    end else begin
                        want = pending_rsps.pop_front();
                        if (rsp_if.ok !== want.ok)
                            report("ok", rsp_if.ok, want.ok);
                        if (rsp_if.read_value !== want.read_value)
                            report("read_value", rsp_if.read_value, want.read_value);
                        if (rsp_if.position !== want.position)
                            report("position", rsp_if.position, want.position);
                        if (rsp_if.count !== want.count)
                            report("count", rsp_if.count, want.count);
                        if (rsp_if.is_empty !== want.is_empty)
                            report("is_empty", rsp_if.is_empty, want.is_empty);
                        if (rsp_if.is_full !== want.is_full)
                            report("is_full", rsp_if.is_full, want.is_full);
                        if (rsp_if.sorted_up !== want.sorted_up)
                            report("sorted_up", rsp_if.sorted_up, want.sorted_up);
                        if (rsp_if.sorted_down !== want.sorted_down)
                            report("sorted_down", rsp_if.sorted_down, want.sorted_down);
                        // Directed rows also carry a hand-written outcome.
                        if (want.fixed && (rsp_if.ok !== want.fixed_ok
                                           || rsp_if.count !== want.fixed_count))
                            report("directed ok/count", {rsp_if.ok, rsp_if.count},
                                   {want.fixed_ok, want.fixed_count});
                    end
                end
            end
        end
    end

    initial begin
        bit growing;
        int roll;
        logic [3:0] func;
        logic [CW-1:0] idx;
        for (int i = 0; i < CAP; i++)
            shadow_list[i] = '0;
        req_if.valid = 1'b0;
        req_if.func  = bale_pkg::F_STATUS;
        req_if.index = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k])
            send_request(steps[k].func, steps[k].index, steps[k].value,
                         steps[k].fixed, steps[k].ok, steps[k].count);

        // Alternate growing and shrinking so that both the full and the empty list recur.
        growing = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (shadow_count == CAP || (growing && $urandom_range(0, 49) == 0))
                growing = 1'b0;
            else if (shadow_count == 0 || (!growing && $urandom_range(0, 49) == 0))
                growing = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 30)
                func = growing ? bale_pkg::F_INSERT : bale_pkg::F_REMOVE;
            else if (roll < 36)
                func = growing ? bale_pkg::F_REMOVE : bale_pkg::F_INSERT;
            else if (roll < 44)
                func = bale_pkg::F_READ;
            else if (roll < 52)
                func = bale_pkg::F_SEARCH;
            else if (roll < 60)
                func = bale_pkg::F_REPLACE;
            else if (roll < 72)
                func = growing ? bale_pkg::F_SINS_UP : bale_pkg::F_SINS_DOWN;
            else if (roll < 78)
                func = growing ? bale_pkg::F_SINS_DOWN : bale_pkg::F_SINS_UP;
            else if (roll < 85)
                func = bale_pkg::F_SORT_UP;
            else if (roll < 92)
                func = bale_pkg::F_SORT_DOWN;
            else if (roll < 96)
                func = bale_pkg::F_STATUS;
            else
                func = 4'($urandom_range(F_UNUSED_LO, F_UNUSED_HI));
            idx = ($urandom_range(0, 99) < 85) ? CW'($urandom_range(0, shadow_count))
                                               : CW'($urandom_range(0, CAP));
            send_request(func, idx, pick_value(), 1'b0, 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("bounded_array_list_engine_core test passed");
        else
            $display("bounded_array_list_engine_core test failed");
        $finish;
    end
endmodule
